// ===== design/pmpg_pkg.sv =====
// ---------------------------------------------------------------------------
// pmpg_pkg: shared types and constants of the motion path generator
// Register indexes, mode codes, CORDIC arctangent table and helpers.
// ---------------------------------------------------------------------------
package pmpg_pkg;

  localparam int CordicStagesDef = 16;
  localparam int AngleBitsDef    = 16;
  localparam int CfgIdxW         = 3;
  localparam int CfgDataW        = 48;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_ENABLE = 3'd1,
    REG_START  = 3'd2,
    REG_CENTER = 3'd3,
    REG_AXIS   = 3'd4,
    REG_AMP    = 3'd5,
    REG_RADIUS = 3'd6,
    REG_SPEED  = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    MODE_CIRCLE = 3'd0,
    MODE_LINEAR = 3'd1,
    MODE_EIGHT  = 3'd2,
    MODE_ORBIT  = 3'd3,
    MODE_BOUNCE = 3'd4,
    MODE_HOLD   = 3'd5
  } mode_e;

  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  // CORDIC vector state carried along the chain (Q.30 x/y, 2^32/turn z)
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } cvec_t;

  function automatic logic signed [33:0] atan_turn(input int i);
    logic signed [33:0] r;
    case (i)
      0: r = 34'sd536870912;  1: r = 34'sd316933406;  2: r = 34'sd167458907;
      3: r = 34'sd85004756;   4: r = 34'sd42667331;   5: r = 34'sd21354465;
      6: r = 34'sd10679838;   7: r = 34'sd5340245;    8: r = 34'sd2670163;
      9: r = 34'sd1335087;    10: r = 34'sd667544;    11: r = 34'sd333772;
      12: r = 34'sd166886;    13: r = 34'sd83443;     14: r = 34'sd41722;
      15: r = 34'sd20861;     16: r = 34'sd10430;     17: r = 34'sd5215;
      18: r = 34'sd2608;      19: r = 34'sd1304;      20: r = 34'sd652;
      21: r = 34'sd326;       22: r = 34'sd163;       23: r = 34'sd81;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

  // Q.30 -> Q2.14 with round half up and clamp to +-1.0
  function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
    logic signed [34:0] t;
    logic signed [18:0] r;
    t = 35'(v) + 35'sd32768;
    r = 19'(t >>> 16);
    if (r > 19'sd16384) r = 19'sd16384;
    if (r < -19'sd16384) r = -19'sd16384;
    return 16'(r);
  endfunction

  function automatic logic [15:0] sat16(input logic signed [27:0] v);
    logic [15:0] r;
    if (v > 28'sd32767) r = 16'h7fff;
    else if (v < -28'sd32768) r = 16'h8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

// ===== design/pmpg_cell.sv =====
// ---------------------------------------------------------------------------
// pmpg_cell: one CORDIC micro-rotation
// Registered rotation of both vectors by +-atan(2^-STEP); side data rides along.
// ---------------------------------------------------------------------------
module pmpg_cell #(
  parameter int STEP   = 0,
  parameter int SIDE_W = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic                  en_i,
  input  pmpg_pkg::cvec_t       a_i,
  input  pmpg_pkg::cvec_t       b_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  valid_o,
  output pmpg_pkg::cvec_t       a_o,
  output pmpg_pkg::cvec_t       b_o,
  output logic [SIDE_W-1:0]     side_o
);

  pmpg_pkg::cvec_t a_d, b_d, a_q, b_q;
  logic [SIDE_W-1:0] side_q;
  logic valid_q;

  function automatic pmpg_pkg::cvec_t rot(input pmpg_pkg::cvec_t v);
    pmpg_pkg::cvec_t r;
    if (!v.z[33]) begin
      r.x = v.x - (v.y >>> STEP);
      r.y = v.y + (v.x >>> STEP);
      r.z = v.z - pmpg_pkg::atan_turn(STEP);
    end else begin
      r.x = v.x + (v.y >>> STEP);
      r.y = v.y - (v.x >>> STEP);
      r.z = v.z + pmpg_pkg::atan_turn(STEP);
    end
    return r;
  endfunction

  always_comb begin
    a_d = rot(a_i);
    b_d = rot(b_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q    <= a_d;
      b_q    <= b_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign a_o     = a_q;
  assign b_o     = b_q;
  assign side_o  = side_q;

endmodule

// ===== design/pmpg_phase.sv =====
// ---------------------------------------------------------------------------
// pmpg_phase: time to CORDIC start vectors
// Three stages: time*speed, times turns-per-radian, fold and seed.
// ---------------------------------------------------------------------------
module pmpg_phase #(
  parameter int ANGLE_BITS = pmpg_pkg::AngleBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [31:0]            time_now_i,
  input  logic signed [15:0]     speed_i,
  output logic                   valid_o,
  output pmpg_pkg::cvec_t        a_o,
  output pmpg_pkg::cvec_t        b_o,
  output logic [1:0]             flip_o
);

  localparam logic [31:0] PhaseMask = ~((32'h1 << (32 - ANGLE_BITS)) - 32'h1);

  logic [2:0] valid_q;
  logic signed [48:0] prod_q;
  logic [31:0] lo_hi_q, lo_lo_q, hi_lo_q;
  logic [31:0] phase;
  logic [31:0] phase2;
  pmpg_pkg::cvec_t a_q, b_q;
  logic [1:0] flip_q;

  // 64-bit product of the Q.24 radians with 683565276, split in halves
  logic [63:0] mul_sum;
  assign mul_sum = {32'h0, lo_lo_q} + {lo_hi_q, 32'h0} + {hi_lo_q, 32'h0};
  assign phase  = mul_sum[55:24] & PhaseMask;
  assign phase2 = {phase[30:0], 1'b0};

  function automatic void seed(input logic [31:0] ph,
                               output pmpg_pkg::cvec_t v, output logic f);
    logic [31:0] p;
    f = (ph >= 32'h4000_0000) && (ph < 32'hC000_0000);
    p = f ? ph - 32'h8000_0000 : ph;
    v.x = pmpg_pkg::CordicGain;
    v.y = 34'sd0;
    v.z = 34'($signed(p));
  endfunction

  logic [63:0] p64;
  assign p64 = 64'($signed(prod_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 3'b000;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    pmpg_pkg::cvec_t va, vb;
    logic fa, fb;
    if (en_i) begin
      prod_q  <= $signed({1'b0, time_now_i}) * speed_i;
      lo_lo_q <= 32'((64'(p64[31:0]) * 64'd683565276));
      lo_hi_q <= 32'((64'(p64[31:0]) * 64'd683565276) >> 32);
      hi_lo_q <= 32'(64'(p64[63:32]) * 64'd683565276);
      seed(phase, va, fa);
      seed(phase2, vb, fb);
      a_q    <= va;
      b_q    <= vb;
      flip_q <= {fb, fa};
    end
  end

  assign valid_o = valid_q[2];
  assign a_o     = a_q;
  assign b_o     = b_q;
  assign flip_o  = flip_q;

endmodule

// ===== design/pmpg_path.sv =====
// ---------------------------------------------------------------------------
// pmpg_path: path evaluation, output register sums, rounds and saturates
// Stage 1 rounds trig and forms products, stage 2 forms the orbit products.
// ---------------------------------------------------------------------------
module pmpg_path (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  pmpg_pkg::cvec_t        a_i,
  input  pmpg_pkg::cvec_t        b_i,
  input  logic [1:0]             flip_i,
  input  logic [2:0]             mode_i,
  input  logic                   enable_i,
  input  logic [47:0]            start_i,
  input  logic [47:0]            center_i,
  input  logic [47:0]            axis_i,
  input  logic [31:0]            amp_i,
  input  logic signed [15:0]     radius_i,
  output logic                   valid_o,
  output logic [15:0]            pos_x_o,
  output logic [15:0]            pos_y_o,
  output logic [15:0]            pos_z_o
);

  logic signed [15:0] sx, sy, sz, cx, cy, cz, kx, ky, kz, ax, ay;
  assign sx = start_i[15:0];  assign sy = start_i[31:16];  assign sz = start_i[47:32];
  assign cx = center_i[15:0]; assign cy = center_i[31:16]; assign cz = center_i[47:32];
  assign kx = axis_i[15:0];   assign ky = axis_i[31:16];   assign kz = axis_i[47:32];
  assign ax = amp_i[15:0];    assign ay = amp_i[31:16];

  logic signed [33:0] xa, ya, yb;
  logic signed [15:0] cs, sn, s2;
  assign xa = flip_i[0] ? -a_i.x : a_i.x;
  assign ya = flip_i[0] ? -a_i.y : a_i.y;
  assign yb = flip_i[1] ? -b_i.y : b_i.y;
  assign cs = pmpg_pkg::to_q14(xa);
  assign sn = pmpg_pkg::to_q14(ya);
  assign s2 = pmpg_pkg::to_q14(yb);

  logic signed [16:0] vx, vy, vz;
  assign vx = 17'(sx) - 17'(cx);
  assign vy = 17'(sy) - 17'(cy);
  assign vz = 17'(sz) - 17'(cz);

  // stage 1
  logic [1:0] valid_q;
  logic signed [31:0] rc_q, rs_q, r2_q, as_q, ab_q;
  logic signed [15:0] cs_q, sn_q;
  logic signed [47:0] dot_q;
  logic signed [34:0] crx_q, cry_q, crz_q;
  // stage 2
  logic signed [48:0] vcx_q, vcy_q, vcz_q;
  logic signed [52:0] csx_q, csy_q, csz_q;
  logic signed [48:0] kdx_q, kdy_q, kdz_q;
  logic signed [31:0] rc2_q, rs2_q, r22_q, as2_q, ab2_q;

  logic signed [15:0] sn_abs;
  assign sn_abs = sn[15] ? -sn : sn;

  logic signed [33:0] dot_r;
  assign dot_r = 34'((dot_q + 48'sd8192) >>> 14);
  logic signed [16:0] omc;
  assign omc = 17'sd16384 - 17'(cs_q);
  logic signed [50:0] kd;
  assign kd = 51'(dot_r) * 51'(omc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 2'b00;
    end else if (en_i) begin
      valid_q <= {valid_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rc_q  <= radius_i * cs;
      rs_q  <= radius_i * sn;
      r2_q  <= radius_i * s2;
      as_q  <= ax * sn;
      ab_q  <= ay * sn_abs;
      cs_q  <= cs;
      sn_q  <= sn;
      dot_q <= 48'(kx * vx) + 48'(ky * vy) + 48'(kz * vz);
      crx_q <= 35'(ky * vz) - 35'(kz * vy);
      cry_q <= 35'(kz * vx) - 35'(kx * vz);
      crz_q <= 35'(kx * vy) - 35'(ky * vx);
      vcx_q <= 49'(vx * cs_q) <<< 14;
      vcy_q <= 49'(vy * cs_q) <<< 14;
      vcz_q <= 49'(vz * cs_q) <<< 14;
      csx_q <= 53'(crx_q) * 53'(sn_q);
      csy_q <= 53'(cry_q) * 53'(sn_q);
      csz_q <= 53'(crz_q) * 53'(sn_q);
      kdx_q <= 49'(kd) ;
      kdy_q <= 49'(kd) ;
      kdz_q <= 49'(kd) ;
      rc2_q <= rc_q; rs2_q <= rs_q; r22_q <= r2_q; as2_q <= as_q; ab2_q <= ab_q;
    end
  end

  // kx*dot*omc: dot*omc registered, axis product here (16x49)
  logic signed [54:0] ox, oy, oz;
  assign ox = 55'(vcx_q) + 55'(csx_q) + 55'(kx) * 55'(kdx_q);
  assign oy = 55'(vcy_q) + 55'(csy_q) + 55'(ky) * 55'(kdy_q);
  assign oz = 55'(vcz_q) + 55'(csz_q) + 55'(kz) * 55'(kdz_q);

  // an unnormalized axis can push the orbit terms well past 16 bits
  function automatic logic signed [27:0] rsh(input logic signed [54:0] v, input int s);
    return 28'((v + (55'sd1 <<< (s - 1))) >>> s);
  endfunction

  logic signed [27:0] px, py, pz;
  always_comb begin
    px = 28'(sx); py = 28'(sy); pz = 28'(sz);
    if (enable_i) begin
      case (mode_i)
        pmpg_pkg::MODE_CIRCLE: begin
          px = 28'(cx) + rsh(55'(rc2_q), 14);
          py = 28'(cy) + 28'(sy);
          pz = 28'(cz) + rsh(55'(rs2_q), 14);
        end
        pmpg_pkg::MODE_LINEAR: px = 28'(sx) + rsh(55'(as2_q), 14);
        pmpg_pkg::MODE_EIGHT: begin
          px = 28'(cx) + rsh(55'(rs2_q), 14);
          py = 28'(cy) + rsh(55'(r22_q), 15);
          pz = 28'(cz);
        end
        pmpg_pkg::MODE_ORBIT: begin
          px = 28'(cx) + rsh(ox, 28);
          py = 28'(cy) + rsh(oy, 28);
          pz = 28'(cz) + rsh(oz, 28);
        end
        pmpg_pkg::MODE_BOUNCE: py = 28'(sy) + rsh(55'(ab2_q), 14);
        default: ;
      endcase
    end
  end

  logic [15:0] x_q, y_q, z_q;
  logic vo_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= valid_q[1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= pmpg_pkg::sat16(px);
      y_q <= pmpg_pkg::sat16(py);
      z_q <= pmpg_pkg::sat16(pz);
    end
  end

  assign valid_o = vo_q;
  assign pos_x_o = x_q;
  assign pos_y_o = y_q;
  assign pos_z_o = z_q;

endmodule

// ===== design/parametric_motion_path_generator.sv =====
// ---------------------------------------------------------------------------
// parametric_motion_path_generator: time stamp to 3D path position
// Throughput: one word per cycle; the pipeline (phase, CORDIC cell chain,
// path math) advances whenever the output register is free or taken.
// Reset: configuration registers return to their reset values, pipeline empties.
// ---------------------------------------------------------------------------
module parametric_motion_path_generator #(
  parameter int CORDIC_STAGES = pmpg_pkg::CordicStagesDef,
  parameter int ANGLE_BITS    = pmpg_pkg::AngleBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [31:0]                   time_now_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic signed [15:0]            pos_x_o,
  output logic signed [15:0]            pos_y_o,
  output logic signed [15:0]            pos_z_o,
  input  logic                          cfg_we_i,
  input  logic [pmpg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pmpg_pkg::CfgDataW-1:0] cfg_data_i
);

  logic [2:0]  mode_q;
  logic        enable_q;
  logic [47:0] start_q, center_q, axis_q;
  logic [31:0] amp_q;
  logic [15:0] radius_q, speed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= pmpg_pkg::MODE_CIRCLE;
      enable_q <= 1'b1;
      start_q  <= '0;
      center_q <= '0;
      axis_q   <= 48'd1073741824;
      amp_q    <= 32'd16777472;
      radius_q <= 16'd768;
      speed_q  <= 16'd256;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pmpg_pkg::REG_MODE:   mode_q   <= cfg_data_i[2:0];
        pmpg_pkg::REG_ENABLE: enable_q <= cfg_data_i[0];
        pmpg_pkg::REG_START:  start_q  <= cfg_data_i[47:0];
        pmpg_pkg::REG_CENTER: center_q <= cfg_data_i[47:0];
        pmpg_pkg::REG_AXIS:   axis_q   <= cfg_data_i[47:0];
        pmpg_pkg::REG_AMP:    amp_q    <= cfg_data_i[31:0];
        pmpg_pkg::REG_RADIUS: radius_q <= cfg_data_i[15:0];
        pmpg_pkg::REG_SPEED:  speed_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // whole pipeline stalls together while the output word waits
  logic en;
  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;

  pmpg_pkg::cvec_t a_c [CORDIC_STAGES+1];
  pmpg_pkg::cvec_t b_c [CORDIC_STAGES+1];
  logic [1:0]      f_c [CORDIC_STAGES+1];
  logic            v_c [CORDIC_STAGES+1];

  pmpg_phase #(.ANGLE_BITS(ANGLE_BITS)) u_phase (
    .clk_i, .rst_ni, .en_i(en), .valid_i(valid_i), .time_now_i,
    .speed_i(speed_q), .valid_o(v_c[0]), .a_o(a_c[0]), .b_o(b_c[0]),
    .flip_o(f_c[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    pmpg_cell #(.STEP(g), .SIDE_W(2)) u_cell (
      .clk_i, .rst_ni, .valid_i(v_c[g]), .en_i(en),
      .a_i(a_c[g]), .b_i(b_c[g]), .side_i(f_c[g]),
      .valid_o(v_c[g+1]), .a_o(a_c[g+1]), .b_o(b_c[g+1]), .side_o(f_c[g+1])
    );
  end

  pmpg_path u_path (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_c[CORDIC_STAGES]),
    .a_i(a_c[CORDIC_STAGES]), .b_i(b_c[CORDIC_STAGES]), .flip_i(f_c[CORDIC_STAGES]),
    .mode_i(mode_q), .enable_i(enable_q), .start_i(start_q), .center_i(center_q),
    .axis_i(axis_q), .amp_i(amp_q), .radius_i(radius_q), .valid_o(valid_o),
    .pos_x_o(pos_x_o), .pos_y_o(pos_y_o), .pos_z_o(pos_z_o)
  );

endmodule
